>>> src/pble_pkg.sv
// Shared types and constants for the postfix bitwise logic evaluator.
package pble_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int WORD_W      = 64;
    localparam int KIND_W      = 3;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Instruction kind codes on the input channel
    localparam logic [KIND_W-1:0] KIND_PUSH_OPERAND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_ONES    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PUSH_ZERO    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT          = 3'd3;
    localparam logic [KIND_W-1:0] KIND_AND          = 3'd4;
    localparam logic [KIND_W-1:0] KIND_OR           = 3'd5;
    localparam logic [KIND_W-1:0] KIND_XOR          = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNSUP        = 3'd7;

    // Program status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_UNSUP = 2'd3
    } status_t;

    // Classified operation class
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_NOT   = 2'd1,
        OP_BIN   = 2'd2,
        OP_UNSUP = 2'd3
    } op_t;

    // Two-operand function
    typedef enum logic [1:0] {
        BIN_AND = 2'd0,
        BIN_OR  = 2'd1,
        BIN_XOR = 2'd2
    } bin_t;

    // One decoded instruction as it travels from front to back
    typedef struct packed {
        op_t               op;
        bin_t              bin;
        logic [WORD_W-1:0] word;
        logic              last;
    } item_t;

endpackage

>>> src/postfix_bitwise_logic_evaluator_unit.sv
// Top level of the postfix bitwise logic evaluator.
// Usage:
//   The s_ channel carries one instruction per beat: s_kind selects push
//   operand, push ones, push zero, NOT, AND, OR, XOR or unsupported;
//   s_operand is the word pushed by a push-operand beat; s_last ends the
//   program. Only a beat with s_last set produces an m_ beat, carrying
//   m_result (bottom stack word, zero if empty or unsupported) and m_status
//   (ok, underflow, overflow, unsupported).
//   Throughput: one instruction per cycle while s_ready is high. The front
//   decode stage feeds a four-entry queue; the back unit executes one
//   instruction each cycle unless a last one waits for the result register,
//   with the top two stack words in registers and deeper words in a spill
//   memory whose next entry is prefetched every cycle. With the queue empty,
//   a last beat goes through the decode register, then the queue entry, then
//   the result register before it shows on m_valid.
//   When m_ready is low, non-last instructions keep executing; a last
//   instruction waits in the queue until the result register frees, and
//   s_ready drops once the queue and decode stage are full.
//   Reset (aresetn low, synchronous) empties the stack, clears the status
//   and the queue; stack memory contents need no clearing pass.
module postfix_bitwise_logic_evaluator_unit
    import pble_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [WORD_W-1:0] s_operand,
    input  logic              s_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_result,
    output logic [1:0]        m_status
);

    logic  f_valid, f_ready;
    item_t f_item;
    logic  q_valid, q_ready;
    item_t q_item;

    pble_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_operand (s_operand),
        .s_last    (s_last),
        .f_valid   (f_valid),
        .f_ready   (f_ready),
        .f_item    (f_item)
    );

    pble_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    pble_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result),
        .m_status (m_status)
    );

endmodule

>>> src/pble_front.sv
// Front end: takes input beats, decodes the kind, holds one decoded item.
module pble_front
    import pble_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [WORD_W-1:0] s_operand,
    input  logic              s_last,
    output logic              f_valid,
    input  logic              f_ready,
    output item_t             f_item
);

    logic  valid_reg, valid_next;
    item_t item_reg;
    item_t dec;

    // Decode kind into an operation class and a push word
    always_comb begin
        dec.op   = OP_PUSH;
        dec.bin  = BIN_AND;
        dec.word = '0;
        dec.last = s_last;
        unique case (s_kind)
            KIND_PUSH_OPERAND: dec.word = s_operand;
            KIND_PUSH_ONES:    dec.word = '1;
            KIND_PUSH_ZERO:    dec.word = '0;
            KIND_NOT:          dec.op   = OP_NOT;
            KIND_AND: begin
                dec.op  = OP_BIN;
                dec.bin = BIN_AND;
            end
            KIND_OR: begin
                dec.op  = OP_BIN;
                dec.bin = BIN_OR;
            end
            KIND_XOR: begin
                dec.op  = OP_BIN;
                dec.bin = BIN_XOR;
            end
            KIND_UNSUP:        dec.op   = OP_UNSUP;
            default:           dec.op   = OP_UNSUP;
        endcase
    end

    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_item  = item_reg;

    // Holding stage valid
    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (f_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= dec;
        end
    end

endmodule

>>> src/pble_queue.sv
// Short FIFO of decoded items between front and back.
module pble_queue
    import pble_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push, pop;

    assign in_ready  = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill tracking
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> src/pble_back.sv
// Back end: executes stack instructions and registers the program result.
module pble_back
    import pble_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  item_t             q_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_result,
    output logic [1:0]        m_status
);

    // Top two entries live in registers; deeper entries spill to memory.
    logic [WORD_W-1:0] mem [STACK_DEPTH];
    logic [WORD_W-1:0] tos_reg, tos_next;
    logic [WORD_W-1:0] nos_reg, nos_next;
    logic [WORD_W-1:0] bottom_reg, bottom_next;
    logic [WORD_W-1:0] rd_reg;
    logic [CNT_W-1:0]  count_reg, count_next, count_op;
    status_t           status_reg, status_next, status_op;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] result_reg, result_next;
    status_t           out_status_reg;

    logic              exec;
    logic              out_free;
    logic              mem_we;
    logic [CNT_W-1:0]  waddr_w, raddr_w;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [WORD_W-1:0] bin_res;

    assign out_free = !out_valid_reg || m_ready;
    assign exec     = q_valid && (!q_item.last || out_free);
    assign q_ready  = exec;

    assign m_valid  = out_valid_reg;
    assign m_result = result_reg;
    assign m_status = out_status_reg;

    // Two-operand function on the top pair
    always_comb begin
        case (q_item.bin)
            BIN_AND: bin_res = nos_reg & tos_reg;
            BIN_OR:  bin_res = nos_reg | tos_reg;
            BIN_XOR: bin_res = nos_reg ^ tos_reg;
            default: bin_res = nos_reg ^ tos_reg;
        endcase
    end

    // Instruction execution
    always_comb begin
        tos_next    = tos_reg;
        nos_next    = nos_reg;
        bottom_next = bottom_reg;
        count_op    = count_reg;
        status_op   = status_reg;
        mem_we      = 1'b0;
        waddr_w     = count_reg - CNT_W'(2);
        if (exec && status_reg != ST_UNSUP) begin
            case (q_item.op)
                OP_PUSH: begin
                    if (count_reg == CNT_W'(STACK_DEPTH)) begin
                        if (status_reg == ST_OK) status_op = ST_OVER;
                    end else begin
                        tos_next = q_item.word;
                        nos_next = tos_reg;
                        count_op = count_reg + CNT_W'(1);
                        if (count_reg >= CNT_W'(2)) mem_we = 1'b1;
                        if (count_reg == CNT_W'(2)) bottom_next = nos_reg;
                    end
                end
                OP_NOT: begin
                    if (count_reg == '0) begin
                        if (status_reg == ST_OK) status_op = ST_UNDER;
                    end else begin
                        tos_next = ~tos_reg;
                    end
                end
                OP_BIN: begin
                    if (count_reg < CNT_W'(2)) begin
                        if (status_reg == ST_OK) status_op = ST_UNDER;
                    end else begin
                        tos_next = bin_res;
                        nos_next = rd_reg;
                        count_op = count_reg - CNT_W'(1);
                    end
                end
                default: status_op = ST_UNSUP;
            endcase
        end
    end

    // End of program: form result, clear count and status
    always_comb begin
        count_next     = count_op;
        status_next    = status_op;
        out_valid_next = out_valid_reg && !m_ready;
        result_next    = '0;
        if (status_op != ST_UNSUP) begin
            if (count_op == CNT_W'(1)) begin
                result_next = tos_next;
            end else if (count_op == CNT_W'(2)) begin
                result_next = nos_next;
            end else if (count_op != '0) begin
                result_next = bottom_next;
            end
        end
        if (exec && q_item.last) begin
            count_next     = '0;
            status_next    = ST_OK;
            out_valid_next = 1'b1;
        end
    end

    // Prefetch address: entry just below the new second entry
    assign raddr_w = count_next - CNT_W'(3);
    assign raddr   = raddr_w[ADDR_W-1:0];
    assign waddr   = waddr_w[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stack word registers
    always_ff @(posedge aclk) begin
        tos_reg    <= tos_next;
        nos_reg    <= nos_next;
        bottom_reg <= bottom_next;
    end

    // Spill memory; a spill lands at the prefetch address, so bypass it
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= nos_reg;
            rd_reg     <= nos_reg;
        end else begin
            rd_reg     <= mem[raddr];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (exec && q_item.last) begin
            result_reg     <= result_next;
            out_status_reg <= status_op;
        end
    end

endmodule

>>> tb/tb_top.sv
// Testbench for the postfix bitwise logic evaluator: directed and random programs.
module tb_top;
    import pble_pkg::*;

    // Expected outcome of one program
    typedef struct {
        logic [WORD_W-1:0] result;
        status_t           status;
    } prog_result_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [KIND_W-1:0] s_kind;
    logic [WORD_W-1:0] s_operand;
    logic              s_last;
    logic              m_valid;
    logic              m_ready;
    logic [WORD_W-1:0] m_result;
    logic [1:0]        m_status;

    // Shadow stack machine
    logic [WORD_W-1:0] eval_stack [STACK_DEPTH];
    int                eval_depth;
    status_t           eval_status;

    prog_result_t      pending_results [$];
    int                errors;
    int                instr_sent;
    bit                tx_gaps;
    bit                rx_stalls;
    bit                rx_long;
    int                stall_left;

    postfix_bitwise_logic_evaluator_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_operand (s_operand),
        .s_last    (s_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .m_status  (m_status)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle length: mostly none or short, sometimes long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return {$urandom(), $urandom()};
    endfunction

    function automatic logic [KIND_W-1:0] pick_push();
        int r;
        r = $urandom_range(0, 5);
        if (r < 4)
            return KIND_PUSH_OPERAND;
        else if (r == 4)
            return KIND_PUSH_ONES;
        else
            return KIND_PUSH_ZERO;
    endfunction

    // Pick a legal next instruction for a stack holding at least two words
    function automatic logic [KIND_W-1:0] pick_op(input int depth);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && depth < 6)
            return pick_push();
        else if (r == 4)
            return KIND_NOT;
        else if (r % 3 == 0)
            return KIND_AND;
        else if (r % 3 == 1)
            return KIND_OR;
        else
            return KIND_XOR;
    endfunction

    function automatic void note_fault(input status_t code);
        if (eval_status == ST_OK)
            eval_status = code;
    endfunction

    function automatic void push_word(input logic [WORD_W-1:0] w);
        if (eval_depth >= STACK_DEPTH) begin
            note_fault(ST_OVER);
        end else begin
            eval_stack[eval_depth] = w;
            eval_depth++;
        end
    endfunction

    // Execute one instruction on the shadow stack; queue the outcome on last
    function automatic void eval_instr(input logic [KIND_W-1:0] kind,
                                       input logic [WORD_W-1:0] operand,
                                       input logic last);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        prog_result_t      outcome;
        if (eval_status != ST_UNSUP) begin
            case (kind)
                KIND_PUSH_OPERAND: push_word(operand);
                KIND_PUSH_ONES:    push_word('1);
                KIND_PUSH_ZERO:    push_word('0);
                KIND_NOT: begin
                    if (eval_depth < 1)
                        note_fault(ST_UNDER);
                    else
                        eval_stack[eval_depth-1] = ~eval_stack[eval_depth-1];
                end
                KIND_AND, KIND_OR, KIND_XOR: begin
                    if (eval_depth < 2) begin
                        note_fault(ST_UNDER);
                    end else begin
                        a = eval_stack[eval_depth-2];
                        b = eval_stack[eval_depth-1];
                        if (kind == KIND_AND)
                            a = a & b;
                        else if (kind == KIND_OR)
                            a = a | b;
                        else
                            a = a ^ b;
                        eval_stack[eval_depth-2] = a;
                        eval_depth--;
                    end
                end
                default: eval_status = ST_UNSUP;
            endcase
        end
        if (last) begin
            if (eval_status == ST_UNSUP || eval_depth == 0)
                outcome.result = '0;
            else
                outcome.result = eval_stack[0];
            outcome.status = eval_status;
            pending_results.insert(pending_results.size(), outcome);
            eval_depth  = 0;
            eval_status = ST_OK;
        end
    endfunction

    // Drive one instruction beat and wait for it to be taken
    task automatic send_instr(input logic [KIND_W-1:0] kind,
                              input logic [WORD_W-1:0] operand,
                              input logic last);
        int gap;
        gap = tx_gaps ? idle_len() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_operand <= operand;
        s_last    <= last;
        do @(posedge aclk); while (!s_ready);
        eval_instr(kind, operand, last);
        instr_sent++;
    endtask

    // Hold off the sender until every queued program result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // One program: leading pushes, then legal ops; noisy or one bad slot on request
    task automatic send_program(input int len, input int lead_push,
                                input bit noisy, input int bad_at);
        int                depth;
        logic [KIND_W-1:0] k;
        depth = 0;
        for (int i = 0; i < len; i++) begin
            if (noisy || i == bad_at)
                k = KIND_W'($urandom_range(0, 7));
            else if (i < lead_push || depth < 1)
                k = pick_push();
            else if (depth < 2)
                k = ($urandom_range(0, 1) != 0) ? KIND_NOT : pick_push();
            else
                k = pick_op(depth);
            if (k == KIND_PUSH_OPERAND || k == KIND_PUSH_ONES || k == KIND_PUSH_ZERO) begin
                if (depth < STACK_DEPTH)
                    depth++;
            end else if (k == KIND_AND || k == KIND_OR || k == KIND_XOR) begin
                if (depth >= 2)
                    depth--;
            end
            send_instr(k, random_word(), i == len - 1);
        end
    endtask

    // Receiver: random stalls, optionally long ones
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            stall_left = rx_long ? $urandom_range(10, 30) : idle_len();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge aclk) begin : chk
        prog_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, result %h status %0d",
                         $time, m_result, m_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_result !== want.result) begin
                    $display("%0t: result mismatch, expected %h actual %h",
                             $time, want.result, m_result);
                    errors++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, m_status);
                    errors++;
                end
            end
        end
    end

    // Every operation, operand extremes, underflow, unsupported, empty stack
    task automatic test_directed();
        send_instr(KIND_PUSH_OPERAND, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_instr(KIND_PUSH_OPERAND, 64'h0123_4567_89AB_CDEF, 1'b0);
        send_instr(KIND_AND, 64'h0, 1'b0);
        send_instr(KIND_NOT, 64'h0, 1'b1);
        send_instr(KIND_PUSH_ONES, 64'h5555_5555_5555_5555, 1'b0);
        send_instr(KIND_PUSH_ZERO, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_instr(KIND_OR, 64'h0, 1'b0);
        send_instr(KIND_PUSH_OPERAND, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_instr(KIND_XOR, 64'h0, 1'b1);
        // binary op on an empty stack
        send_instr(KIND_AND, 64'h0, 1'b1);
        send_instr(KIND_PUSH_OPERAND, 64'h0, 1'b1);
        // underflow, execution goes on
        send_instr(KIND_PUSH_ONES, 64'h0, 1'b0);
        send_instr(KIND_XOR, 64'h0, 1'b0);
        send_instr(KIND_NOT, 64'h0, 1'b0);
        send_instr(KIND_PUSH_OPERAND, 64'h8000_0000_0000_0001, 1'b1);
        // unsupported op discards the rest
        send_instr(KIND_PUSH_ONES, 64'h0, 1'b0);
        send_instr(KIND_UNSUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_instr(KIND_PUSH_ZERO, 64'h0, 1'b1);
        // unsupported overrides an earlier underflow
        send_instr(KIND_NOT, 64'h0, 1'b0);
        send_instr(KIND_UNSUP, 64'h0, 1'b1);
    endtask

    // Full stack, overflow, and first error wins in both orders
    task automatic test_overflow();
        for (int i = 0; i <= STACK_DEPTH; i++)
            send_instr(pick_push(), random_word(), 1'b0);
        for (int i = 0; i < STACK_DEPTH - 1; i++)
            send_instr(KIND_XOR, random_word(), 1'b0);
        send_instr(KIND_XOR, random_word(), 1'b1);
        send_instr(KIND_NOT, random_word(), 1'b0);
        for (int i = 0; i <= STACK_DEPTH; i++)
            send_instr(pick_push(), random_word(), i == STACK_DEPTH);
    endtask

    // Back-to-back short programs against long receiver stalls
    task automatic test_backpressure();
        tx_gaps = 1'b0;
        rx_long = 1'b1;
        for (int i = 0; i < 30; i++)
            send_instr(pick_push(), random_word(), 1'b1);
        rx_long = 1'b0;
        tx_gaps = 1'b1;
    endtask

    // Programs separated by a full drain of the pipeline
    task automatic test_drain_pauses();
        for (int i = 0; i < 6; i++) begin
            send_program($urandom_range(1, 6), 0, 1'b0, -1);
            wait_drained();
        end
    endtask

    // Mostly legal programs with random content, some broken, some noise
    task automatic test_random_programs();
        int target;
        int r;
        bit quiet;
        target = instr_sent + 280;
        while (instr_sent < target) begin
            quiet     = ($urandom_range(0, 5) == 0);
            tx_gaps   = !quiet;
            rx_stalls = !quiet;
            r = $urandom_range(0, 99);
            if (r < 2)
                send_program($urandom_range(66, 72), $urandom_range(60, 68), 1'b0, -1);
            else if (r < 70)
                send_program($urandom_range(1, 10), 0, 1'b0, -1);
            else if (r < 85)
                send_program($urandom_range(2, 10), 0, 1'b0, $urandom_range(0, 9));
            else
                send_program($urandom_range(1, 5), 0, 1'b1, -1);
            if ($urandom_range(0, 24) == 0)
                wait_drained();
        end
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    initial begin
        errors      = 0;
        instr_sent  = 0;
        eval_depth  = 0;
        eval_status = ST_OK;
        tx_gaps     = 1'b1;
        rx_stalls   = 1'b1;
        rx_long     = 1'b0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_kind    <= KIND_PUSH_OPERAND;
        s_operand <= '0;
        s_last    <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_overflow();
        test_backpressure();
        test_drain_pauses();
        test_random_programs();

        wait_drained();
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
